@@ design/vrof_pkg.sv @@
// Shared types and constants for the variant record overlap filter.
package vrof_pkg;

    localparam int POSITION_WIDTH_DEF = 31;

    localparam int NUM_FIELDS = 10;
    localparam logic [3:0] LAST_FIELD  = 4'(NUM_FIELDS - 1);
    localparam logic [3:0] START_FIELD = 4'd1;
    localparam logic [3:0] REF_FIELD   = 4'd3;
    localparam logic [3:0] INFO_FIELD  = 4'd7;
    localparam logic [3:0] FIELD_SAT   = 4'd15;

    // INFO length only matters up to "longer than four characters"
    localparam logic [2:0] INFO_LEN_SAT = 3'd5;
    localparam logic [2:0] INFO_LEN_MIN = 3'd4;

    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_NL   = 8'h0a;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_EQ   = 8'h3d;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_N    = 8'h4e;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;

    typedef enum logic [2:0] {
        K_BLANK      = 3'd0,
        K_HEADER     = 3'd1,
        K_KEPT       = 3'd2,
        K_SKIPPED    = 3'd3,
        K_FIELD_ERR  = 3'd4,
        K_NUMBER_ERR = 3'd5
    } kind_t;

    // progress through ";END=" inside INFO
    typedef enum logic [2:0] {
        M_IDLE = 3'd0,
        M_SEMI = 3'd1,
        M_E    = 3'd2,
        M_N    = 3'd3,
        M_D    = 3'd4,
        M_NUM  = 3'd5,
        M_DONE = 3'd6
    } match_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
    } res_ctl_t;

endpackage

@@ design/variant_record_overlap_filter.sv @@
// Top level of the variant record overlap filter.
//
// Slave side: one text character per word on s_tdata; s_tlast marks end of
// stream and acts as a final line end (the character is then ignored).
// Master side: one word per line end: line kind on m_tuser, start and
// inclusive end positions on m_tdata. Blank lines closed by end of stream
// give no word.
// The accepted word is parsed straight out of the input register and its
// result is registered in the result register, which drives m_tvalid.
// Words are taken at one per cycle, set by the per-byte parse step between
// the input and result registers, except while a word that closes a line
// waits on a stalled receiver.
// A field count or number error halts the block: words are still taken but
// nothing more is produced until reset.
// Reset (aresetn low, synchronous) returns to the header phase and forgets
// the last kept record.
// When the receiver stalls, the result waits in its register; the input
// register keeps taking words that close no line, and a word that closes
// a line is held there with s_tready low until the waiting result is taken.
module variant_record_overlap_filter #(
    parameter int POSITION_WIDTH = vrof_pkg::POSITION_WIDTH_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [7:0]                              s_tdata,  // [7:0] text_byte
    input  logic                                    s_tlast,  // end_of_stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // [PW-1:0] start_pos, [2PW-1:PW] end_pos, zero fill to whole bytes
    output logic [((2*POSITION_WIDTH+7)/8)*8-1:0]  m_tdata,
    output logic [2:0]                              m_tuser   // [2:0] line_kind
);
    import vrof_pkg::*;

    localparam int DATA_W = ((2 * POSITION_WIDTH + 7) / 8) * 8;

    logic                      in_valid, in_last, take, out_busy;
    logic [7:0]                in_byte;
    res_ctl_t                  res;
    logic [POSITION_WIDTH-1:0] res_start, res_end, start_pos, end_pos;
    kind_t                     kind;

    vrof_in_reg u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .take     (take),
        .valid    (in_valid),
        .byte_out (in_byte),
        .last_out (in_last)
    );

    // parsing and the overlap decision for the held word
    vrof_parse #(.POSITION_WIDTH(POSITION_WIDTH)) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_busy  (out_busy),
        .in_take   (take),
        .res       (res),
        .res_start (res_start),
        .res_end   (res_end)
    );

    vrof_out_reg #(.POSITION_WIDTH(POSITION_WIDTH)) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res       (res),
        .res_start (res_start),
        .res_end   (res_end),
        .m_tready  (m_tready),
        .valid     (m_tvalid),
        .busy      (out_busy),
        .kind      (kind),
        .start_pos (start_pos),
        .end_pos   (end_pos)
    );

    assign m_tdata = DATA_W'({end_pos, start_pos});
    assign m_tuser = kind;

endmodule

@@ design/vrof_in_reg.sv @@
// Input register holding one accepted text word.
module vrof_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       take,
    output logic       valid,
    output logic [7:0] byte_out,
    output logic       last_out
);
    import vrof_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       load;

    assign s_tready = !valid_reg || take;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign valid    = valid_reg;
    assign byte_out = byte_reg;
    assign last_out = last_reg;

    a_take_needs_word: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> valid_reg)
        else $error("word consumed from empty input register");

endmodule

@@ design/vrof_parse.sv @@
// Per-byte line parser: field tracking, number parsing, END tag search, overlap test.
module vrof_parse #(
    parameter int POSITION_WIDTH = vrof_pkg::POSITION_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  logic [7:0]                in_byte,
    input  logic                      in_last,
    input  logic                      out_busy,
    output logic                      in_take,
    output vrof_pkg::res_ctl_t        res,
    output logic [POSITION_WIDTH-1:0] res_start,
    output logic [POSITION_WIDTH-1:0] res_end
);
    import vrof_pkg::*;

    localparam int PW = POSITION_WIDTH;
    localparam int PX = POSITION_WIDTH + 4;

    logic          in_header_reg,    in_header_next;
    logic          halted_reg,       halted_next;
    logic          line_started_reg, line_started_next;
    logic [3:0]    field_reg,        field_next;
    logic [PW-1:0] start_reg,        start_next;
    logic          start_over_reg,   start_over_next;
    logic          start_stop_reg,   start_stop_next;
    logic [15:0]   ref_len_reg,      ref_len_next;
    logic [2:0]    info_len_reg,     info_len_next;
    match_t        match_reg,        match_next;
    logic          tag_found_reg,    tag_found_next;
    logic [PW-1:0] tag_reg,          tag_next;
    logic          tag_over_reg,     tag_over_next;
    logic [PW:0]   kept_limit_reg,   kept_limit_next;   // last kept end + 1

    logic          is_nl, line_end, emits, is_digit, do_record, use_tag;
    logic [3:0]    digit;
    logic [3:0]    field_inc;
    logic [PX-1:0] start_prod, tag_prod;
    logic [PW:0]   end_a1, end_b1, end_m1, end_lim;
    logic [PW-1:0] end_sat;
    logic          end_clip;
    logic [7:0]    expect_ch;

    assign is_nl    = (in_byte == CH_NL);
    assign line_end = in_last || is_nl;
    // empty line closed by end of stream gives nothing
    assign emits    = !halted_reg && line_end && (line_started_reg || !in_last);
    assign in_take  = in_valid && (!emits || !out_busy);

    assign is_digit  = (in_byte >= CH_0) && (in_byte <= CH_9);
    assign digit     = 4'(in_byte - CH_0);
    assign do_record = !in_header_reg || (!line_started_reg && in_byte != CH_HASH);
    assign field_inc = (field_reg == FIELD_SAT) ? field_reg : field_reg + 4'd1;

    // value*10 + digit, overflow when any bit from PW up is set
    assign start_prod = ({4'b0, start_reg} << 3) + ({4'b0, start_reg} << 1) + PX'(digit);
    assign tag_prod   = ({4'b0, tag_reg} << 3) + ({4'b0, tag_reg} << 1) + PX'(digit);

    // end + 1 = max(start + ref_len, (END value, else start) + 1), clipped at 2^PW
    assign use_tag  = tag_found_reg && (info_len_reg > INFO_LEN_MIN);
    assign end_a1   = {1'b0, start_reg} + (PW + 1)'(ref_len_reg);
    assign end_b1   = {1'b0, (use_tag ? tag_reg : start_reg)} + (PW + 1)'(1);
    assign end_m1   = (end_a1 > end_b1) ? end_a1 : end_b1;
    assign end_clip = end_m1[PW] && (end_m1[PW-1:0] != '0);
    assign end_lim  = end_clip ? {1'b1, {PW{1'b0}}} : end_m1;
    assign end_sat  = end_clip ? {PW{1'b1}} : PW'(end_m1 - (PW + 1)'(1));

    always_comb begin
        case (match_reg)
            M_IDLE:  expect_ch = CH_SEMI;
            M_SEMI:  expect_ch = CH_E;
            M_E:     expect_ch = CH_N;
            M_N:     expect_ch = CH_D;
            M_D:     expect_ch = CH_EQ;
            default: expect_ch = CH_SEMI;
        endcase
    end

    always_comb begin
        in_header_next    = in_header_reg;
        halted_next       = halted_reg;
        line_started_next = line_started_reg;
        field_next        = field_reg;
        start_next        = start_reg;
        start_over_next   = start_over_reg;
        start_stop_next   = start_stop_reg;
        ref_len_next      = ref_len_reg;
        info_len_next     = info_len_reg;
        match_next        = match_reg;
        tag_found_next    = tag_found_reg;
        tag_next          = tag_reg;
        tag_over_next     = tag_over_reg;
        kept_limit_next   = kept_limit_reg;
        res               = '{valid: 1'b0, kind: K_BLANK};
        res_start         = '0;
        res_end           = '0;

        if (in_take && !halted_reg) begin
            if (line_end) begin
                res.valid = emits;
                if (line_started_reg) begin
                    if (in_header_reg) begin
                        res.kind = K_HEADER;
                    end else if (field_reg != LAST_FIELD) begin
                        res.kind    = K_FIELD_ERR;
                        halted_next = 1'b1;
                    end else if (start_over_reg || (use_tag && tag_over_reg)) begin
                        res.kind    = K_NUMBER_ERR;
                        halted_next = 1'b1;
                    end else begin
                        res_start = start_reg;
                        res_end   = end_sat;
                        if ({1'b0, start_reg} >= kept_limit_reg) begin
                            res.kind        = K_KEPT;
                            kept_limit_next = end_lim;
                        end else begin
                            res.kind = K_SKIPPED;
                        end
                    end
                end
                line_started_next = 1'b0;
                field_next        = '0;
                start_next        = '0;
                start_over_next   = 1'b0;
                start_stop_next   = 1'b0;
                ref_len_next      = '0;
                info_len_next     = '0;
                match_next        = M_IDLE;
                tag_found_next    = 1'b0;
                tag_next          = '0;
                tag_over_next     = 1'b0;
            end else begin
                line_started_next = 1'b1;
                if (in_header_reg && !line_started_reg && in_byte != CH_HASH) begin
                    in_header_next = 1'b0;
                end
                if (do_record) begin
                    if (in_byte == CH_TAB) begin
                        field_next = field_inc;
                        if (field_inc == INFO_FIELD) begin
                            match_next = M_SEMI;   // field start acts as ';'
                        end
                    end else if (field_reg == START_FIELD) begin
                        if (!start_stop_reg && !start_over_reg) begin
                            if (!is_digit) begin
                                start_stop_next = 1'b1;
                            end else if (start_prod[PX-1:PW] != '0) begin
                                start_over_next = 1'b1;
                            end else begin
                                start_next = start_prod[PW-1:0];
                            end
                        end
                    end else if (field_reg == REF_FIELD) begin
                        if (ref_len_reg != '1) begin
                            ref_len_next = ref_len_reg + 16'd1;
                        end
                    end else if (field_reg == INFO_FIELD) begin
                        if (info_len_reg != INFO_LEN_SAT) begin
                            info_len_next = info_len_reg + 3'd1;
                        end
                        case (match_reg)
                            M_IDLE, M_SEMI, M_E, M_N, M_D: begin
                                if (in_byte == expect_ch) begin
                                    match_next = match_t'(match_reg + 3'd1);
                                    if (match_reg == M_D) begin
                                        tag_found_next = 1'b1;
                                        tag_next       = '0;
                                    end
                                end else begin
                                    match_next = (in_byte == CH_SEMI) ? M_SEMI : M_IDLE;
                                end
                            end
                            M_NUM: begin
                                if (is_digit && !tag_over_reg) begin
                                    if (tag_prod[PX-1:PW] != '0) begin
                                        tag_over_next = 1'b1;
                                    end else begin
                                        tag_next = tag_prod[PW-1:0];
                                    end
                                end else begin
                                    match_next = M_DONE;
                                end
                            end
                            default: match_next = match_reg;
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_header_reg    <= 1'b1;
            halted_reg       <= 1'b0;
            line_started_reg <= 1'b0;
            field_reg        <= '0;
            start_reg        <= '0;
            start_over_reg   <= 1'b0;
            start_stop_reg   <= 1'b0;
            ref_len_reg      <= '0;
            info_len_reg     <= '0;
            match_reg        <= M_IDLE;
            tag_found_reg    <= 1'b0;
            tag_reg          <= '0;
            tag_over_reg     <= 1'b0;
            kept_limit_reg   <= '0;
        end else begin
            in_header_reg    <= in_header_next;
            halted_reg       <= halted_next;
            line_started_reg <= line_started_next;
            field_reg        <= field_next;
            start_reg        <= start_next;
            start_over_reg   <= start_over_next;
            start_stop_reg   <= start_stop_next;
            ref_len_reg      <= ref_len_next;
            info_len_reg     <= info_len_next;
            match_reg        <= match_next;
            tag_found_reg    <= tag_found_next;
            tag_reg          <= tag_next;
            tag_over_reg     <= tag_over_next;
            kept_limit_reg   <= kept_limit_next;
        end
    end

    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt released without reset");

    a_limit_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> kept_limit_reg >= $past(kept_limit_reg))
        else $error("kept limit moved backwards");

    a_no_pos_on_plain: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && (res.kind == K_BLANK || res.kind == K_HEADER ||
                      res.kind == K_FIELD_ERR || res.kind == K_NUMBER_ERR)
        |-> res_start == '0 && res_end == '0)
        else $error("positions set on a non-record result");

    a_kept_order: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid && res.kind == K_KEPT |-> ({1'b0, res_end} + 1'b1) >= {1'b0, res_start})
        else $error("kept record ends before start - 1");

endmodule

@@ design/vrof_out_reg.sv @@
// Result register feeding the master side.
module vrof_out_reg #(
    parameter int POSITION_WIDTH = vrof_pkg::POSITION_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  vrof_pkg::res_ctl_t        res,
    input  logic [POSITION_WIDTH-1:0] res_start,
    input  logic [POSITION_WIDTH-1:0] res_end,
    input  logic                      m_tready,
    output logic                      valid,
    output logic                      busy,
    output vrof_pkg::kind_t           kind,
    output logic [POSITION_WIDTH-1:0] start_pos,
    output logic [POSITION_WIDTH-1:0] end_pos
);
    import vrof_pkg::*;

    logic                      valid_reg, valid_next;
    kind_t                     kind_reg;
    logic [POSITION_WIDTH-1:0] start_reg, end_reg;

    always_comb begin
        valid_next = valid_reg;
        if (res.valid) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            kind_reg  <= res.kind;
            start_reg <= res_start;
            end_reg   <= res_end;
        end
    end

    assign valid     = valid_reg;
    assign busy      = valid_reg && !m_tready;
    assign kind      = kind_reg;
    assign start_pos = start_reg;
    assign end_pos   = end_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> !valid_reg || m_tready)
        else $error("result overwritten before it was taken");

endmodule
